@@ rtl/swcd_pkg.sv @@
package swcd_pkg;

  // Store geometry and frame limits
  localparam int STORE_DEPTH = 128;
  localparam int MAX_FRAME   = 64;
  localparam int MIN_PARSE   = 9;
  localparam int MIN_FRAME   = 10;

  // Store address width, frame length width, width for count compares
  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int LEN_W = 7;
  localparam int CW    = AW + 1;

  // Register reset values
  localparam logic [31:0] SYNC_RESET    = 32'h5948_5A53;
  localparam logic [3:0]  LEN_OFS_RESET = 4'd5;
  localparam logic [3:0]  CMD_OFS_RESET = 4'd9;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SYNC_WORD      = 2'd0,
    REG_LENGTH_OFFSET  = 2'd1,
    REG_COMMAND_OFFSET = 2'd2
  } cfg_reg_t;

  // Byte store write request
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } store_wr_t;

endpackage

@@ rtl/swcd_store.sv @@
module swcd_store
  import swcd_pkg::*;
(
  input  logic          clk,
  input  store_wr_t     wr,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  // Circular byte store, contents undefined until written
  logic [7:0] mem [STORE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/sync_word_checksum_deframer.sv @@
// Sync-word frame parser. Each received byte is written into a 128-entry circular
// store and then one parse attempt runs over the unparsed bytes: search for the
// little-endian sync word, read the little-endian 32-bit length at length_offset
// (10 to 64 is valid, anything else counts as a false sync), sum all frame bytes
// but the last modulo 256 and compare with the last byte. A good frame goes out
// byte by byte with the command byte and length alongside; a bad one restarts the
// search one byte past the false sync. The block takes no new byte while a parse
// attempt runs. All work goes through the single read port of the store, whose
// read data is registered, so every byte read has a read state and a use state,
// and each emitted byte then waits in a hold state until the sink takes it.
// The store needs no clearing after reset.
module sync_word_checksum_deframer
  import swcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // Received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Frame bytes
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] frame_command,
                                      // [22:16] frame_length, [23] zero
  output logic        m_axis_tlast    // out_last
);

  typedef enum logic [12:0] {
    S_IDLE      = 13'h0001,
    S_CHECK     = 13'h0002,
    S_SRCH_RD   = 13'h0004,
    S_SRCH_USE  = 13'h0008,
    S_LEN_RD    = 13'h0010,
    S_LEN_USE   = 13'h0020,
    S_SUM_RD    = 13'h0040,
    S_SUM_USE   = 13'h0080,
    S_CMD_RD    = 13'h0100,
    S_CMD_USE   = 13'h0200,
    S_EMIT_RD   = 13'h0400,
    S_EMIT_USE  = 13'h0800,
    S_EMIT_HOLD = 13'h1000
  } state_t;

  state_t state;

  // Configuration
  logic [31:0] sync_word;
  logic [3:0]  length_offset;
  logic [3:0]  command_offset;

  // Parser state
  logic [AW-1:0]    read_pos;
  logic [AW-1:0]    write_pos;
  logic             sync_found;
  logic [LEN_W-1:0] expected_len;

  // Sequencer working registers
  logic [AW-1:0] cnt;
  logic [AW-1:0] avail;
  logic [31:0]   window;
  logic [7:0]    sum;
  logic [7:0]    cmd;
  logic [7:0]    out_byte;
  logic          out_last;
  logic          out_valid;

  // Store access
  store_wr_t     st_wr;
  logic [AW-1:0] rd_ofs;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  logic          in_acc;
  logic [AW-1:0] n_unparsed;
  logic [CW-1:0] n_ext;
  logic [CW-1:0] elen_ext;
  logic [AW-1:0] cnt_inc;
  logic [31:0]   window_next;
  logic [AW-1:0] srch_skip;
  logic [AW-1:0] avail_left;
  logic          len_bad;
  logic          frame_end;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !rst;

  assign st_wr.en   = in_acc;
  assign st_wr.addr = write_pos;
  assign st_wr.data = s_axis_tdata;

  // Read offset from read_pos for the current step
  always_comb begin
    unique case (state)
      S_LEN_RD: rd_ofs = AW'(length_offset) + cnt;
      S_CMD_RD: rd_ofs = AW'(command_offset);
      default:  rd_ofs = cnt;
    endcase
  end

  assign rd_addr = read_pos + rd_ofs;

  swcd_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared arithmetic for the sequencer
  assign n_unparsed  = write_pos - read_pos;
  assign n_ext       = CW'(n_unparsed);
  assign elen_ext    = CW'(expected_len);
  assign cnt_inc     = cnt + AW'(1);
  assign window_next = {rd_data, window[31:8]};
  assign srch_skip   = cnt - AW'(3);
  assign avail_left  = avail - srch_skip;
  assign len_bad     = (window_next < 32'(MIN_FRAME)) || (window_next > 32'(MAX_FRAME));
  assign frame_end   = (CW'(cnt_inc) == elen_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sync_word      <= SYNC_RESET;
      length_offset  <= LEN_OFS_RESET;
      command_offset <= CMD_OFS_RESET;
      read_pos       <= '0;
      write_pos      <= '0;
      sync_found     <= 1'b0;
      expected_len   <= '0;
      out_valid      <= 1'b0;
    end else begin
      // Register writes
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_SYNC_WORD:      sync_word      <= cfg_data;
          REG_LENGTH_OFFSET:  length_offset  <= cfg_data[3:0];
          REG_COMMAND_OFFSET: command_offset <= cfg_data[3:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            write_pos <= write_pos + AW'(1);
            state     <= S_CHECK;
          end
        end

        // Decide what this attempt has to do
        S_CHECK: begin
          if ((elen_ext > n_ext) || (n_ext < CW'(MIN_PARSE))) begin
            state <= S_IDLE;
          end else begin
            cnt   <= '0;
            avail <= n_unparsed;
            sum   <= '0;
            if (!sync_found) begin
              state <= S_SRCH_RD;
            end else if (expected_len == '0) begin
              state <= S_LEN_RD;
            end else begin
              state <= S_SUM_RD;
            end
          end
        end

        S_SRCH_RD: state <= S_SRCH_USE;

        // Sliding 4-byte window compare against the sync word
        S_SRCH_USE: begin
          window <= window_next;
          if ((cnt >= AW'(3)) && (window_next == sync_word)) begin
            read_pos   <= read_pos + srch_skip;
            sync_found <= 1'b1;
            cnt        <= '0;
            avail      <= avail_left;
            if (avail_left < AW'(MIN_PARSE)) begin
              state <= S_IDLE;
            end else begin
              state <= S_LEN_RD;
            end
          end else if (cnt_inc == avail) begin
            // keep the last three bytes, they may start a sync word
            read_pos <= read_pos + avail - AW'(3);
            state    <= S_IDLE;
          end else begin
            cnt   <= cnt_inc;
            state <= S_SRCH_RD;
          end
        end

        S_LEN_RD: state <= S_LEN_USE;

        // Gather the length field, then range check it
        S_LEN_USE: begin
          window <= window_next;
          if (cnt == AW'(3)) begin
            if (len_bad) begin
              read_pos     <= read_pos + AW'(1);
              sync_found   <= 1'b0;
              expected_len <= '0;
              state        <= S_IDLE;
            end else begin
              expected_len <= window_next[LEN_W-1:0];
              cnt          <= '0;
              sum          <= '0;
              if (32'(avail) < window_next) begin
                state <= S_IDLE;
              end else begin
                state <= S_SUM_RD;
              end
            end
          end else begin
            cnt   <= cnt_inc;
            state <= S_LEN_RD;
          end
        end

        S_SUM_RD: state <= S_SUM_USE;

        // Checksum over all bytes but the last, compared with the last
        S_SUM_USE: begin
          if (frame_end) begin
            if (sum == rd_data) begin
              state <= S_CMD_RD;
            end else begin
              read_pos     <= read_pos + AW'(1);
              sync_found   <= 1'b0;
              expected_len <= '0;
              state        <= S_IDLE;
            end
          end else begin
            sum   <= sum + rd_data;
            cnt   <= cnt_inc;
            state <= S_SUM_RD;
          end
        end

        S_CMD_RD: state <= S_CMD_USE;

        S_CMD_USE: begin
          cmd   <= rd_data;
          cnt   <= '0;
          state <= S_EMIT_RD;
        end

        S_EMIT_RD: state <= S_EMIT_USE;

        S_EMIT_USE: begin
          out_byte  <= rd_data;
          out_last  <= frame_end;
          out_valid <= 1'b1;
          state     <= S_EMIT_HOLD;
        end

        // Hold the byte until the sink takes it
        S_EMIT_HOLD: begin
          if (m_axis_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              read_pos     <= read_pos + AW'(expected_len);
              sync_found   <= 1'b0;
              expected_len <= '0;
              state        <= S_IDLE;
            end else begin
              cnt   <= cnt_inc;
              state <= S_EMIT_RD;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, expected_len, cmd, out_byte};
  assign m_axis_tlast  = out_last;

endmodule

@@ rtl/swcd_checker.sv @@
module swcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // No byte is taken while a frame byte is on offer
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // A parse attempt follows every accepted byte
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready right after an accepted byte");

  // After a frame byte other than the last is taken, the block is still busy
  a_busy_mid_frame: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> !s_axis_tready)
    else $error("ready in the middle of a frame");

  // A stalled output request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("output request changed while stalled");

endmodule

bind sync_word_checksum_deframer swcd_checker u_swcd_checker (.*);

@@ test/sync_word_checksum_deframer_tb.sv @@
module sync_word_checksum_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swcd_pkg::*;

  localparam int SETTLE   = 800;   // covers a full rescan plus a frame emission
  localparam int WATCHDOG = 4000;  // cycles with no request accepted on either side
  localparam int HOLD_AT  = 126;   // received byte count that triggers the long stall
  localparam int HOLD_LEN = 500;

  // One expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] cmd;
    logic [6:0] len;
    logic       last;
  } frame_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [7:0] out_byte, [15:8] frame_command,
                                    // [22:16] frame_length, [23] zero
  logic        m_axis_tlast;        // out_last

  sync_word_checksum_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Shared state
  logic [7:0]  rx_q[$];
  frame_beat_t frame_q[$];
  logic [31:0] sync_cfg = SYNC_RESET;
  int          lofs_cfg = int'(LEN_OFS_RESET);
  int          cofs_cfg = int'(CMD_OFS_RESET);
  bit          quiet = 1'b0;
  int          rx_accepted = 0;
  int          bytes_queued = 0;
  int          errors = 0;
  int          frames_seen = 0;
  int          beats_seen = 0;
  int          settings_run = 1;

  // Parser mirror: store contents, positions and sync state
  logic [7:0] mirror [STORE_DEPTH];
  int         rd_pos = 0;
  int         wr_pos = 0;
  bit         in_sync = 1'b0;
  int         want_len = 0;

  function automatic logic [7:0] mb(int p);
    return mirror[p % STORE_DEPTH];
  endfunction

  function automatic logic [31:0] mw(int p);
    return {mb(p + 3), mb(p + 2), mb(p + 1), mb(p)};
  endfunction

  function automatic int unparsed();
    int n;
    n = (wr_pos + STORE_DEPTH - rd_pos) % STORE_DEPTH;
    return (want_len > n) ? 0 : n;
  endfunction

  function automatic void drop_sync(int adv);
    rd_pos = (rd_pos + adv) % STORE_DEPTH;
    in_sync = 1'b0;
    want_len = 0;
  endfunction

  // Store one byte and run one parse attempt, queueing any frame it releases
  function automatic void take_byte(logic [7:0] b);
    int          avail;
    int          i;
    int          flen;
    logic [31:0] lw;
    logic [7:0]  sum;
    logic [7:0]  cmd;
    frame_beat_t fb;
    mirror[wr_pos] = b;
    wr_pos = (wr_pos + 1) % STORE_DEPTH;
    avail = unparsed();
    if (avail < MIN_PARSE) return;
    if (!in_sync) begin
      i = 0;
      while (i + 3 < avail && mw(rd_pos + i) != sync_cfg) i++;
      if (i + 3 >= avail) begin
        rd_pos = (rd_pos + avail - 3) % STORE_DEPTH;
        return;
      end
      in_sync = 1'b1;
      rd_pos = (rd_pos + i) % STORE_DEPTH;
      // recount from the new start
      avail = unparsed();
      if (avail < MIN_PARSE) return;
    end
    if (want_len == 0) begin
      lw = mw(rd_pos + lofs_cfg);
      if (lw < 32'(MIN_FRAME) || lw > 32'(MAX_FRAME)) begin
        drop_sync(1);
        return;
      end
      want_len = int'(lw);
      if (avail < want_len) return;
    end
    flen = want_len;
    sum = '0;
    for (i = 0; i + 1 < flen; i++) sum = sum + mb(rd_pos + i);
    if (sum != mb(rd_pos + flen - 1)) begin
      drop_sync(1);
      return;
    end
    cmd = mb(rd_pos + cofs_cfg);
    for (i = 0; i < flen; i++) begin
      fb.data = mb(rd_pos + i);
      fb.cmd  = cmd;
      fb.len  = 7'(flen);
      fb.last = (i + 1 == flen);
      frame_q.push_back(fb);
    end
    drop_sync(flen);
  endfunction

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      take_byte(s_axis_tdata);
      rx_accepted <= rx_accepted + 1;
    end
  end

  // Byte sender: random gap bursts separated by calm stretches
  int send_gap = 0;
  int send_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet && send_calm == 0 && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(1, 13) - 1;
        send_calm = $urandom_range(0, 30);
        s_axis_tvalid <= 1'b0;
      end else if (rx_q.size() > 0) begin
        if (send_calm > 0) send_calm--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rx_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Frame receiver: checks each beat, stalls in bursts and once for a long stretch
  int  recv_gap = 0;
  int  recv_calm = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  task automatic report(string field, logic [7:0] want, logic [7:0] got);
    $display("%0t ns: %s expected %h, actual %h", $time, field, want, got);
    errors++;
  endtask

  always @(posedge clk) begin
    frame_beat_t fb;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        beats_seen++;
        if (m_axis_tlast) frames_seen++;
        if (frame_q.size() == 0) begin
          $display("%0t ns: frame byte expected none, actual %h last %b", $time,
                   m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          fb = frame_q.pop_front();
          if (m_axis_tdata[7:0] !== fb.data) report("out_byte", fb.data, m_axis_tdata[7:0]);
          if (m_axis_tdata[15:8] !== fb.cmd)
            report("frame_command", fb.cmd, m_axis_tdata[15:8]);
          if (m_axis_tdata[22:16] !== fb.len)
            report("frame_length", 8'(fb.len), 8'(m_axis_tdata[22:16]));
          if (m_axis_tdata[23] !== 1'b0) report("pad bit", 8'd0, 8'(m_axis_tdata[23]));
          if (m_axis_tlast !== fb.last) report("out_last", 8'(fb.last), 8'(m_axis_tlast));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && rx_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && recv_calm == 0 && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 13) - 1;
        recv_calm = $urandom_range(0, 40);
        m_axis_tready <= 1'b0;
      end else begin
        if (recv_calm > 0) recv_calm--;
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no accepted request
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout after %0d idle cycles, %0d frame bytes outstanding",
                 idle_cycles, frame_q.size());
        $display("sync_word_checksum_deframer: mismatch");
        $finish;
      end
    end
  end

  // Stimulus helpers
  task automatic put_byte(logic [7:0] b);
    rx_q.push_back(b);
    bytes_queued++;
  endtask

  // fault: 0 good, 1 bad checksum, 2 cut short
  task automatic send_frame(int len, logic [31:0] len_field, int fault);
    logic [7:0] fr [64];
    logic [7:0] sum;
    int         k;
    int         n;
    for (k = 0; k < len; k++) fr[k] = 8'($urandom);
    for (k = 0; k < 4; k++)
      if (lofs_cfg + k < len) fr[lofs_cfg + k] = len_field[8*k +: 8];
    for (k = 0; k < 4; k++) fr[k] = sync_cfg[8*k +: 8];
    sum = '0;
    for (k = 0; k + 1 < len; k++) sum = sum + fr[k];
    fr[len - 1] = sum + 8'(fault == 1);
    n = (fault == 2) ? $urandom_range(4, len - 1) : len;
    for (k = 0; k < n; k++) put_byte(fr[k]);
  endtask

  // Mostly short frames; length field must fit ahead of the checksum byte
  function automatic int pick_len();
    int lo;
    int hi;
    if (lofs_cfg < 4) return int'(sync_cfg);
    lo = (lofs_cfg + 5 < MIN_FRAME) ? MIN_FRAME : lofs_cfg + 5;
    hi = (lo + 8 > MAX_FRAME) ? MAX_FRAME : lo + 8;
    if ($urandom_range(0, 4) != 0) return $urandom_range(lo, hi);
    return $urandom_range(lo, MAX_FRAME);
  endfunction

  task automatic random_traffic(int budget);
    int          start;
    int          r;
    int          k;
    logic [31:0] bad;
    start = bytes_queued;
    while (bytes_queued - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        k = pick_len();
        send_frame(k, k, 0);
      end else if (r < 70) begin
        k = pick_len();
        send_frame(k, k, 1);
      end else if (r < 78) begin
        case ($urandom_range(0, 2))
          0: bad = $urandom_range(0, MIN_FRAME - 1);
          1: bad = $urandom_range(MAX_FRAME + 1, 255);
          default: bad = $urandom | 32'h0000_0100;
        endcase
        send_frame(pick_len(), bad, 0);
      end else if (r < 85) begin
        k = pick_len();
        send_frame(k, k, 2);
      end else begin
        repeat ($urandom_range(1, 8))
          put_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end
    end
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_SYNC_WORD:      sync_cfg = val;
      REG_LENGTH_OFFSET:  lofs_cfg = int'(val[3:0]);
      REG_COMMAND_OFFSET: cofs_cfg = int'(val[3:0]);
      default: ;
    endcase
  endtask

  // Wait until every byte is taken and every frame delivered, then let the parser finish
  task automatic drain();
    while (rx_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (frame_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic new_setting(logic [31:0] sw, logic [3:0] lo, logic [3:0] co);
    drain();
    write_reg(REG_SYNC_WORD, sw);
    write_reg(REG_LENGTH_OFFSET, 32'(lo));
    write_reg(REG_COMMAND_OFFSET, 32'(co));
    settings_run++;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: length limits, bad lengths, bad checksum, late sync.
    // With these offsets every read stays inside the received bytes, and
    // the whole store is written before the offsets change.
    send_frame(MIN_FRAME, MIN_FRAME, 0);
    send_frame(MAX_FRAME, MAX_FRAME, 0);
    send_frame(12, MIN_FRAME - 1, 0);
    send_frame(12, MAX_FRAME + 1, 0);
    send_frame(12, 32'h0100_000C, 0);
    send_frame(12, 12, 1);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h53);
    put_byte(8'h5A);
    send_frame(MIN_FRAME, MIN_FRAME, 0);
    random_traffic(50);

    // All-ones sync, furthest length field, command at frame start
    new_setting(32'hFFFF_FFFF, 4'd15, 4'd0);
    random_traffic(25);

    // Length field overlays the sync word, command at furthest offset
    new_setting(32'd24, 4'd0, 4'd15);
    random_traffic(25);

    // All-zero sync: runs of zeros give false syncs with bad lengths
    new_setting(32'h0000_0000, 4'd4, 4'd3);
    repeat (12) put_byte(8'h00);
    random_traffic(15);

    new_setting($urandom, 4'($urandom_range(4, 15)), 4'($urandom));
    random_traffic(25);

    // Back to reset values, no idling on either side
    new_setting(SYNC_RESET, LEN_OFS_RESET, CMD_OFS_RESET);
    quiet = 1'b1;
    random_traffic(15);
    drain();

    $display("received %0d bytes under %0d register settings", rx_accepted, settings_run);
    $display("delivered %0d frames, %0d frame bytes checked", frames_seen, beats_seen);
    if (errors == 0 && frame_q.size() == 0) begin
      $display("sync_word_checksum_deframer: match");
    end else begin
      $display("sync_word_checksum_deframer: mismatch");
    end
    $finish;
  end

endmodule
